FILE: design/sme_pkg.sv
// Package of shared types and constants for the stack machine execute unit.
package sme_pkg;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_SUB  = 5'd1,
		OP_MULT = 5'd2,
		OP_DIV  = 5'd3,
		OP_EQ   = 5'd4,
		OP_DIFF = 5'd5,
		OP_LT   = 5'd6,
		OP_LTE  = 5'd7,
		OP_GT   = 5'd8,
		OP_GTE  = 5'd9,
		OP_NOT  = 5'd10,
		OP_AND  = 5'd11,
		OP_OR   = 5'd12,
		OP_PUSH = 5'd13,
		OP_DUP  = 5'd14,
		OP_POP  = 5'd15,
		OP_UJP  = 5'd16,
		OP_CJP  = 5'd17,
		OP_SET  = 5'd18,
		OP_GET  = 5'd19
	} opcode_t;

	typedef enum logic [1:0] {
		FLT_OK        = 2'd0,
		FLT_OPERAND   = 2'd1,
		FLT_UNDERFLOW = 2'd2,
		FLT_OVERFLOW  = 2'd3
	} fault_t;

	// Stack cell commands, applied by every cell in the same cycle.
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_PUSH  = 2'd1,
		CELL_POP   = 2'd2,
		CELL_SETT  = 2'd3
	} cell_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} state_t;

	// Control handed to the cell row.
	typedef struct packed {
		cell_cmd_t   cmd;
		logic [31:0] top;
		logic        pop_first;
	} cell_ctl_t;

endpackage

FILE: design/sme_cell.sv
// One stack cell: holds one entry and shifts with its neighbours.
module sme_cell (
	input  logic                clk,
	input  sme_pkg::cell_ctl_t  ctl,
	input  logic [31:0]         above,
	input  logic [31:0]         below,
	input  logic                is_top,
	output logic [31:0]         value
);
	import sme_pkg::*;

	logic [31:0] value_q;

	// Push takes the entry below, pop the entry above; the top cell takes new data.
	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			CELL_PUSH: value_q <= is_top ? ctl.top : below;
			CELL_POP: begin
				if (is_top)
					value_q <= ctl.pop_first ? above : ctl.top;
				else
					value_q <= above;
			end
			CELL_SETT: if (is_top) value_q <= ctl.top;
			default: value_q <= value_q;
		endcase
	end

	assign value = value_q;
endmodule

FILE: design/sme_divider.sv
// Restoring divider for unsigned 32-bit magnitudes, one quotient bit per cycle.
module sme_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import sme_pkg::*;

	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, div_q};

	// Shift in one dividend bit each cycle and subtract where it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = busy_q && (cnt_q == 6'd1);
	assign quotient = trial[32] ? {quo_q[30:0], 1'b0} : {quo_q[30:0], 1'b1};
endmodule

FILE: design/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit with its row of stack cells.
// Each request passes through the decode state and the done state before its result
// is registered; MULT also waits on the product register, and a division with a
// nonzero divisor on the bit-serial divider. One request is in the unit at a time;
// the next is taken the cycle after the result is accepted.
// Reset clears the depth, program counter, variables and handshake state;
// stack entries are undefined until pushed.
module stack_machine_execute_unit #(
	parameter int STACK_DEPTH  = 64,
	parameter int PROGRAM_SIZE = 256,
	parameter int VAR_COUNT    = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode[4:0], operand[36:5], zero fill [39:37]
	input  logic [39:0] s_tdata,
	// line_start
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// next_pc[7:0], top_value[39:8], stack_depth[46:40], fault[48:47], zero fill [55:49]
	output logic [55:0] m_tdata
);
	import sme_pkg::*;

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int PW = (PROGRAM_SIZE > 1) ? $clog2(PROGRAM_SIZE) : 1;
	localparam int VW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
	// Reciprocal of the program size for the jump distance remainder.
	localparam logic [32:0] JM = 33'(((64'd1 << (32 + PW)) + 64'(PROGRAM_SIZE) - 64'd1)
		/ 64'(PROGRAM_SIZE));
	// Weight of the operand sign bit, 2^32, reduced by the program size.
	localparam longint unsigned JK = (64'd1 << 32) % 64'(PROGRAM_SIZE);

	state_t      state_q, state_d;
	logic [4:0]  mode_q;
	logic [31:0] op_q;
	logic [DW-1:0] depth_q, depth_d;
	logic [PW-1:0] pc_q, pc_d, pc_cur_q;
	logic [31:0] vars_q [VAR_COUNT];
	logic [31:0] cells [STACK_DEPTH];
	cell_ctl_t   ctl;
	logic [1:0]  fault_d;
	logic        var_we;
	logic [31:0] t, s;
	logic [63:0] prod_s1;
	logic        prod_st_q;
	logic        div_start, div_done;
	logic [31:0] div_quo, ua, ub;
	logic        neg_q;
	logic [7:0]  out_pc_q;
	logic [31:0] out_top_q;
	logic [6:0]  out_depth_q;
	logic [1:0]  out_fault_q;
	logic        out_valid_q;
	logic [PW-1:0] pc_next1, pc_jump;
	logic [PW+1:0] jsum;
	logic [63+PW:0] jprod;
	logic [31:0] jq_s1;
	logic [31:0] jrem;
	logic        op_ok;
	logic [VW-1:0] vidx;

	assign t = cells[0];
	assign s = cells[1];
	assign vidx = op_q[VW-1:0];
	assign op_ok = (op_q < 32'(VAR_COUNT));

	// Row of identical stack cells, index zero at the top.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		sme_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.above ((i + 1 < STACK_DEPTH) ? cells[(i + 1) % STACK_DEPTH] : 32'd0),
			.below ((i > 0) ? cells[(i + STACK_DEPTH - 1) % STACK_DEPTH] : 32'd0),
			.is_top(i == 0),
			.value (cells[i])
		);
	end

	assign ua = s[31] ? 32'd0 - s : s;
	assign ub = t[31] ? 32'd0 - t : t;

	sme_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(ua),
		.divisor (ub),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Quotient of the raw operand by the program size, registered at acceptance.
	assign jprod = (64+PW)'(s_tdata[36:5]) * (64+PW)'(JM);

	// Relative jump target, wrapping modulo the program size.
	assign pc_next1 = (32'(pc_cur_q) + 32'd1 >= 32'(PROGRAM_SIZE)) ? '0 : pc_cur_q + PW'(1);
	always_comb begin
		jrem = op_q - jq_s1 * 32'(PROGRAM_SIZE);
		jsum = {2'b00, pc_cur_q} + {2'b00, jrem[PW-1:0]};
		if (op_q[31]) jsum = jsum - (PW+2)'(JK);
		if (jsum[PW+1]) jsum = jsum + (PW+2)'(PROGRAM_SIZE);
		else if (jsum >= (PW+2)'(PROGRAM_SIZE)) jsum = jsum - (PW+2)'(PROGRAM_SIZE);
		pc_jump = jsum[PW-1:0];
	end

	assign s_tready = (state_q == ST_IDLE) && !out_valid_q;

	// Multiplier product register.
	always_ff @(posedge clk) prod_s1 <= s * t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
			prod_st_q   <= 1'b0;
			for (int i = 0; i < VAR_COUNT; i++) vars_q[i] <= '0;
		end else begin
			state_q   <= state_d;
			depth_q   <= depth_d;
			pc_q      <= pc_d;
			prod_st_q <= (state_q == ST_MUL);
			if (var_we) vars_q[vidx] <= t;
			if (state_q == ST_DONE) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q   <= s_tdata[4:0];
			op_q     <= s_tdata[36:5];
			pc_cur_q <= s_tuser ? '0 : pc_q;
			jq_s1    <= jprod[32+PW +: 32];
		end
		if (state_q == ST_EXEC || state_q == ST_DIV || state_q == ST_MUL)
			out_fault_q <= fault_d;
		if (state_q == ST_EXEC) neg_q <= s[31] ^ t[31];
		if (state_q == ST_DONE) begin
			out_pc_q    <= 8'(pc_q);
			out_top_q   <= (depth_q != '0) ? t : 32'd0;
			out_depth_q <= 7'(depth_q);
		end
	end

	// Instruction sequencer: decode, drive the cell row, settle pc and depth.
	always_comb begin
		state_d   = state_q;
		depth_d   = depth_q;
		pc_d      = pc_q;
		fault_d   = FLT_OK;
		ctl.cmd   = CELL_HOLD;
		ctl.top   = '0;
		ctl.pop_first = 1'b1;
		var_we    = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: if (s_tvalid && s_tready) state_d = ST_EXEC;
			ST_EXEC: begin
				state_d = ST_DONE;
				pc_d    = pc_next1;
				priority if (mode_q <= 5'd12 && mode_q != OP_NOT) begin
					if (depth_q < DW'(2)) fault_d = FLT_UNDERFLOW;
					else if (mode_q == OP_MULT) state_d = ST_MUL;
					else if (mode_q == OP_DIV) begin
						if (t != 32'd0) begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end
					end else begin
						ctl.cmd = CELL_POP;
						ctl.pop_first = 1'b0;
						depth_d = depth_q - DW'(1);
						unique case (mode_q)
							OP_ADD:  ctl.top = s + t;
							OP_SUB:  ctl.top = s - t;
							OP_EQ:   ctl.top = {31'd0, s == t};
							OP_DIFF: ctl.top = {31'd0, s != t};
							OP_LT:   ctl.top = {31'd0, $signed(t) < $signed(s)};
							OP_LTE:  ctl.top = {31'd0, $signed(t) <= $signed(s)};
							OP_GT:   ctl.top = {31'd0, $signed(t) > $signed(s)};
							OP_GTE:  ctl.top = {31'd0, $signed(t) >= $signed(s)};
							OP_AND:  ctl.top = {31'd0, (s != 0) && (t != 0)};
							default: ctl.top = {31'd0, (s != 0) || (t != 0)};
						endcase
					end
				end else if (mode_q == OP_NOT || mode_q == OP_POP || mode_q == OP_CJP) begin
					if (depth_q == '0) fault_d = FLT_UNDERFLOW;
					else if (mode_q == OP_NOT) begin
						ctl.cmd = CELL_SETT;
						ctl.top = {31'd0, t == 32'd0};
					end else if (mode_q == OP_CJP && t != 0 && op_q == 0) begin
						fault_d = FLT_OPERAND;
					end else begin
						if (mode_q == OP_CJP && t != 0) pc_d = pc_jump;
						ctl.cmd = CELL_POP;
						depth_d = depth_q - DW'(1);
					end
				end else if (mode_q == OP_PUSH || mode_q == OP_DUP) begin
					if (mode_q == OP_DUP && depth_q == '0) fault_d = FLT_UNDERFLOW;
					else if (depth_q >= DW'(STACK_DEPTH)) fault_d = FLT_OVERFLOW;
					else begin
						ctl.cmd = CELL_PUSH;
						ctl.top = (mode_q == OP_PUSH) ? op_q : t;
						depth_d = depth_q + DW'(1);
					end
				end else if (mode_q == OP_UJP) begin
					if (op_q == 0) fault_d = FLT_OPERAND;
					else pc_d = pc_jump;
				end else if (mode_q == OP_SET || mode_q == OP_GET) begin
					if (!op_ok) fault_d = FLT_OPERAND;
					else if (mode_q == OP_SET) begin
						if (depth_q == '0) fault_d = FLT_UNDERFLOW;
						else begin
							var_we  = 1'b1;
							ctl.cmd = CELL_POP;
							depth_d = depth_q - DW'(1);
						end
					end else if (depth_q >= DW'(STACK_DEPTH)) fault_d = FLT_OVERFLOW;
					else begin
						ctl.cmd = CELL_PUSH;
						ctl.top = vars_q[vidx];
						depth_d = depth_q + DW'(1);
					end
				end else begin
					fault_d = FLT_OPERAND;
				end
				if (fault_d == FLT_UNDERFLOW || fault_d == FLT_OVERFLOW) pc_d = pc_cur_q;
			end
			ST_MUL: begin
				if (prod_st_q) begin
					ctl.cmd = CELL_POP;
					ctl.pop_first = 1'b0;
					ctl.top = prod_s1[31:0];
					depth_d = depth_q - DW'(1);
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					ctl.cmd = CELL_POP;
					ctl.pop_first = 1'b0;
					ctl.top = neg_q ? 32'd0 - div_quo : div_quo;
					depth_d = depth_q - DW'(1);
					state_d = ST_DONE;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_fault_q, out_depth_q, out_top_q, out_pc_q};

	// A request is never taken while a result is still waiting.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !s_tready) else $error("request accepted with result pending");
	// Depth never exceeds the stack size.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH)) else $error("stack depth out of range");
	// A result is valid in the cycle after the sequencer reaches its done state.
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid_q) else $error("result lost");
endmodule
